### sv/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, constants and helper functions of the gravity particle step
// core.
// ----------------------------------------------------------------------------
package gps_pkg;

   // Number of gravity source entries in the table.
   localparam int MAX_SOURCES = 8;

   // Width of the shared adder. It holds the largest product, |d| * R^2 * G *
   // T * 2^32 (below 2^256), and the aligned divisor den * 2^64 (below 2^270).
   localparam int WIDE_W = 272;
   // den = 1000 * D^3, below 2^206.
   localparam int DEN_W = 208;
   // Serial multiplier operand, large enough for the distance D (below 2^65).
   localparam int MB_W = 66;
   // Square root working registers, for a sum of squares below 2^130.
   localparam int ROOT_W = 131;
   localparam int ROOT_STEPS = 66;
   localparam int CNT_W = 7;

   localparam int GRAV_DIV = 1000;
   localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;
   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP    = 2'd0,
      CSR_SOURCE_COUNT = 2'd1,
      CSR_HALTED       = 2'd2
   } csr_index_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [WIDE_W-1:0] value;
      logic              ge;
   } alu_res_type;

   typedef struct packed {
      logic [2:0][63:0] pos;
      logic [31:0]      grav;
      logic [47:0]      rad;
   } src_entry_type;

   // Adds a signed magnitude to a two's complement value, saturating.
   function automatic logic [63:0] sat_add(logic [63:0] base, logic neg, logic [63:0] mag);
      logic [63:0] b;
      logic [64:0] s;
      logic [63:0] r;
      b = base ^ SIGN64;
      if (!neg) begin
         s = {1'b0, b} + {1'b0, mag};
         r = s[64] ? '1 : s[63:0];
      end else begin
         s = {1'b0, b} - {1'b0, mag};
         r = s[64] ? '0 : s[63:0];
      end
      return r ^ SIGN64;
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

endpackage

### sv/gps_wide_alu.sv
// ----------------------------------------------------------------------------
// gps_wide_alu
// Shared wide adder and subtractor with an unsigned greater-or-equal flag.
// ----------------------------------------------------------------------------
module gps_wide_alu (
   input  logic [gps_pkg::WIDE_W-1:0] op_a,
   input  logic [gps_pkg::WIDE_W-1:0] op_b,
   input  gps_pkg::alu_op_type        op,
   output gps_pkg::alu_res_type       res
);

   logic              sub;
   logic [gps_pkg::WIDE_W:0] total;

   assign sub = (op == gps_pkg::ALU_SUB);
   // A carry out of the subtraction means no borrow, so op_a >= op_b.
   assign total = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{gps_pkg::WIDE_W{1'b0}}, sub};

   assign res.value = total[gps_pkg::WIDE_W-1:0];
   assign res.ge    = sub & total[gps_pkg::WIDE_W];

endmodule

### sv/gps_src_table.sv
// ----------------------------------------------------------------------------
// gps_src_table
// Gravity source table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module gps_src_table #(
   parameter int DEPTH  = gps_pkg::MAX_SOURCES,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  gps_pkg::src_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output gps_pkg::src_entry_type rd_data
);

   gps_pkg::src_entry_type mem [DEPTH];
   gps_pkg::src_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gravity_particle_step_core.sv
// Work per particle: for each active source, the time follows the operand bit
// lengths of a shift-and-add multiplier, a 66-step square root and a 64-step
// divider on one shared adder.
// Throughput: one particle at a time; loads are taken every cycle while idle.
// Reset: synchronous, active high; no clearing pass, the source table is unset.
// ----------------------------------------------------------------------------
// gravity_particle_step_core
// Semi-implicit Euler step of particles under inverse-square gravity from a
// small table of sources, computed on one shared wide adder under a sequencer.
// ----------------------------------------------------------------------------
module gravity_particle_step_core #(
   parameter int MAX_SOURCES = gps_pkg::MAX_SOURCES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Item input channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [2:0]                        req_slot,
   input  logic signed [63:0]                req_pos_x,
   input  logic signed [63:0]                req_pos_y,
   input  logic signed [63:0]                req_pos_z,
   input  logic signed [63:0]                req_vel_x,
   input  logic signed [63:0]                req_vel_y,
   input  logic signed [63:0]                req_vel_z,
   input  logic [31:0]                       req_surface_gravity,
   input  logic [47:0]                       req_body_radius,
   input  logic                              req_batch_end,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [63:0]                rsp_new_pos_x,
   output logic signed [63:0]                rsp_new_pos_y,
   output logic signed [63:0]                rsp_new_pos_z,
   output logic signed [63:0]                rsp_new_vel_x,
   output logic signed [63:0]                rsp_new_vel_y,
   output logic signed [63:0]                rsp_new_vel_z,
   output logic                              rsp_batch_end_out,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SRC_AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int SRC_CW = $clog2(MAX_SOURCES + 1);
   localparam int WW     = gps_pkg::WIDE_W;
   localparam int MBW    = gps_pkg::MB_W;
   localparam int RW     = gps_pkg::ROOT_W;
   localparam int DW     = gps_pkg::DEN_W;
   localparam int CW     = gps_pkg::CNT_W;

   // The sequencer walks each source through: distance, square root, the
   // denominator 1000 * D^3, the numerator constant R^2 * G * T * 2^32, and
   // then a multiply and divide for each axis. Every product runs through the
   // shared adder in MUL_RUN and returns to the state held in ret_ff.
   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_SRC_RD   = 20'h00002,
      ST_SRC_DIFF = 20'h00004,
      ST_SQ_NEXT  = 20'h00008,
      ST_ROOT_RUN = 20'h00010,
      ST_D2_SET   = 20'h00020,
      ST_D3_SET   = 20'h00040,
      ST_DEN_SET  = 20'h00080,
      ST_R2_SET   = 20'h00100,
      ST_RG_SET   = 20'h00200,
      ST_RGT_SET  = 20'h00400,
      ST_K_SET    = 20'h00800,
      ST_MUL_RUN  = 20'h01000,
      ST_DIV_CHK  = 20'h02000,
      ST_DIV_RUN  = 20'h04000,
      ST_VEL_ADD  = 20'h08000,
      ST_SRC_NEXT = 20'h10000,
      ST_MOVE_SET = 20'h20000,
      ST_MOVE_ADD = 20'h40000,
      ST_FINISH   = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   // Configuration registers.
   logic [31:0] time_step_ff, time_step_in;
   logic [3:0]  source_count_ff, source_count_in;
   logic        halted_ff, halted_in;

   // Working registers of the shared unit.
   logic [WW-1:0]  acc_ff, acc_in;
   logic [WW-1:0]  ma_ff, ma_in;
   logic [MBW-1:0] mb_ff, mb_in;
   logic [WW-1:0]  dv_ff, dv_in;
   logic [WW-1:0]  k_ff, k_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [RW-1:0]  res_ff, res_in;
   logic [RW-1:0]  one_ff, one_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [63:0]    q_ff, q_in;
   logic [1:0]     ax_ff, ax_in;
   logic [SRC_CW-1:0] src_ff, src_in;

   // Particle state and per-source distance terms.
   logic [2:0][63:0] p_ff, p_in;
   logic [2:0][63:0] v_ff, v_in;
   logic [2:0][63:0] mag_ff, mag_in;
   logic [2:0]       neg_ff, neg_in;
   logic             bend_ff, bend_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0][63:0] rsp_p_ff, rsp_v_ff;
   logic             rsp_bend_ff;
   logic             rsp_load;

   // Table and adder connections.
   logic                   tbl_we, tbl_re;
   gps_pkg::src_entry_type tbl_wdata, tbl_rdata;
   logic [WW-1:0]          alu_a, alu_b;
   gps_pkg::alu_op_type    alu_op;
   gps_pkg::alu_res_type   alu_res;

   logic [2:0][63:0] mag_c;
   logic [2:0]       neg_c;
   logic [1:0]       ax_nx;
   logic [SRC_CW-1:0] src_nx;
   logic [SRC_CW-1:0] n_src;
   logic [63:0]      sa, sb;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign ax_nx     = ax_ff + 2'd1;
   assign src_nx    = src_ff + {{(SRC_CW-1){1'b0}}, 1'b1};

   // A source count above the table depth uses the whole table.
   assign n_src = (int'(source_count_ff) > MAX_SOURCES) ? SRC_CW'(MAX_SOURCES)
                                                         : SRC_CW'(source_count_ff);

   assign tbl_wdata.pos  = {req_pos_z, req_pos_y, req_pos_x};
   assign tbl_wdata.grav = req_surface_gravity;
   assign tbl_wdata.rad  = req_body_radius;

   // Distance from the particle to the source, per axis, as sign and magnitude.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sa       = tbl_rdata.pos[c] ^ gps_pkg::SIGN64;
         sb       = p_ff[c] ^ gps_pkg::SIGN64;
         neg_c[c] = (sa < sb);
         mag_c[c] = neg_c[c] ? (sb - sa) : (sa - sb);
      end
   end

   gps_src_table #(
      .DEPTH  (MAX_SOURCES),
      .ADDR_W (SRC_AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (SRC_AW'(req_slot)),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (src_ff[SRC_AW-1:0]),
      .rd_data (tbl_rdata)
   );

   gps_wide_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .op   (alu_op),
      .res  (alu_res)
   );

   // Configuration writes.
   always_comb begin
      time_step_in    = time_step_ff;
      source_count_in = source_count_ff;
      halted_in       = halted_ff;
      if (csr_valid) begin
         case (csr_index)
            gps_pkg::CSR_TIME_STEP:    time_step_in    = csr_wdata[31:0];
            gps_pkg::CSR_SOURCE_COUNT: source_count_in = csr_wdata[3:0];
            gps_pkg::CSR_HALTED:       halted_in       = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer and datapath control.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      acc_in   = acc_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      dv_in    = dv_ff;
      k_in     = k_ff;
      den_in   = den_ff;
      res_in   = res_ff;
      one_in   = one_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      ax_in    = ax_ff;
      src_in   = src_ff;
      p_in     = p_ff;
      v_in     = v_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      bend_in  = bend_ff;
      tbl_we   = 1'b0;
      tbl_re   = 1'b0;
      rsp_load = 1'b0;
      alu_a    = acc_ff;
      alu_b    = ma_ff;
      alu_op   = gps_pkg::ALU_ADD;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  // Loads outside the table are dropped.
                  tbl_we = (int'(req_slot) < MAX_SOURCES);
               end else begin
                  p_in    = {req_pos_z, req_pos_y, req_pos_x};
                  v_in    = {req_vel_z, req_vel_y, req_vel_x};
                  bend_in = req_batch_end;
                  if (halted_ff) begin
                     state_in = ST_FINISH;
                  end else if (n_src == '0) begin
                     ax_in    = 2'd0;
                     state_in = ST_MOVE_SET;
                  end else begin
                     src_in   = '0;
                     state_in = ST_SRC_RD;
                  end
               end
            end
         end
         ST_SRC_RD: begin
            tbl_re   = 1'b1;
            state_in = ST_SRC_DIFF;
         end
         ST_SRC_DIFF: begin
            mag_in   = mag_c;
            neg_in   = neg_c;
            ax_in    = 2'd0;
            acc_in   = '0;
            ma_in    = WW'(mag_c[0]);
            mb_in    = MBW'(mag_c[0]);
            ret_in   = ST_SQ_NEXT;
            state_in = ST_MUL_RUN;
         end
         ST_SQ_NEXT: begin
            if (ax_ff != 2'd2) begin
               ax_in    = ax_nx;
               ma_in    = WW'(mag_ff[ax_nx]);
               mb_in    = MBW'(mag_ff[ax_nx]);
               ret_in   = ST_SQ_NEXT;
               state_in = ST_MUL_RUN;
            end else if (acc_ff == '0) begin
               // The particle sits on the source: no pull from it.
               state_in = ST_SRC_NEXT;
            end else begin
               res_in   = '0;
               one_in   = {1'b1, {(RW-1){1'b0}}};
               cnt_in   = CW'(gps_pkg::ROOT_STEPS - 1);
               state_in = ST_ROOT_RUN;
            end
         end
         ST_ROOT_RUN: begin
            // Digit-by-digit integer square root of the sum of squares.
            alu_b  = WW'(res_ff | one_ff);
            alu_op = gps_pkg::ALU_SUB;
            if (alu_res.ge) begin
               acc_in = alu_res.value;
               res_in = (res_ff >> 1) | one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_D2_SET;
            end
         end
         ST_D2_SET: begin
            acc_in   = '0;
            ma_in    = WW'(res_ff);
            mb_in    = res_ff[MBW-1:0];
            ret_in   = ST_D3_SET;
            state_in = ST_MUL_RUN;
         end
         ST_D3_SET: begin
            acc_in   = '0;
            ma_in    = acc_ff;
            mb_in    = res_ff[MBW-1:0];
            ret_in   = ST_DEN_SET;
            state_in = ST_MUL_RUN;
         end
         ST_DEN_SET: begin
            acc_in   = '0;
            ma_in    = acc_ff;
            mb_in    = MBW'(gps_pkg::GRAV_DIV);
            ret_in   = ST_R2_SET;
            state_in = ST_MUL_RUN;
         end
         ST_R2_SET: begin
            den_in   = acc_ff[DW-1:0];
            acc_in   = '0;
            ma_in    = WW'(tbl_rdata.rad);
            mb_in    = MBW'(tbl_rdata.rad);
            ret_in   = ST_RG_SET;
            state_in = ST_MUL_RUN;
         end
         ST_RG_SET: begin
            acc_in   = '0;
            ma_in    = acc_ff;
            mb_in    = MBW'(tbl_rdata.grav);
            ret_in   = ST_RGT_SET;
            state_in = ST_MUL_RUN;
         end
         ST_RGT_SET: begin
            acc_in   = '0;
            ma_in    = acc_ff;
            mb_in    = MBW'(time_step_ff);
            ret_in   = ST_K_SET;
            state_in = ST_MUL_RUN;
         end
         ST_K_SET: begin
            // The 2^32 scale of the velocity format is a plain shift.
            k_in     = acc_ff << 32;
            ma_in    = acc_ff << 32;
            mb_in    = MBW'(mag_ff[0]);
            acc_in   = '0;
            ax_in    = 2'd0;
            ret_in   = ST_DIV_CHK;
            state_in = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            // Shift-and-add multiply, one multiplier bit per cycle.
            if (mb_ff == '0) begin
               state_in = ret_ff;
            end else begin
               if (mb_ff[0]) begin
                  acc_in = alu_res.value;
               end
               ma_in = ma_ff << 1;
               mb_in = mb_ff >> 1;
            end
         end
         ST_DIV_CHK: begin
            // A quotient of 2^64 or more saturates without dividing.
            alu_b  = WW'({den_ff, 64'd0});
            alu_op = gps_pkg::ALU_SUB;
            q_in   = '0;
            if (alu_res.ge) begin
               q_in     = '1;
               state_in = ST_VEL_ADD;
            end else begin
               dv_in    = WW'({den_ff, 63'd0});
               cnt_in   = CW'(63);
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            alu_b  = dv_ff;
            alu_op = gps_pkg::ALU_SUB;
            if (alu_res.ge) begin
               acc_in = alu_res.value;
            end
            q_in   = {q_ff[62:0], alu_res.ge};
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_VEL_ADD;
            end
         end
         ST_VEL_ADD: begin
            v_in[ax_ff] = gps_pkg::sat_add(v_ff[ax_ff], neg_ff[ax_ff], q_ff);
            if (ax_ff != 2'd2) begin
               ax_in    = ax_nx;
               acc_in   = '0;
               ma_in    = k_ff;
               mb_in    = MBW'(mag_ff[ax_nx]);
               ret_in   = ST_DIV_CHK;
               state_in = ST_MUL_RUN;
            end else begin
               state_in = ST_SRC_NEXT;
            end
         end
         ST_SRC_NEXT: begin
            src_in = src_nx;
            if (src_nx < n_src) begin
               state_in = ST_SRC_RD;
            end else begin
               ax_in    = 2'd0;
               state_in = ST_MOVE_SET;
            end
         end
         ST_MOVE_SET: begin
            acc_in   = '0;
            ma_in    = WW'(gps_pkg::abs64(v_ff[ax_ff]));
            mb_in    = MBW'(time_step_ff);
            ret_in   = ST_MOVE_ADD;
            state_in = ST_MUL_RUN;
         end
         ST_MOVE_ADD: begin
            // |v| * T in Q31.32 times Q16.16; bits 95:32 are the Q47.16 step.
            p_in[ax_ff] = gps_pkg::sat_add(p_ff[ax_ff], v_ff[ax_ff][63], acc_ff[95:32]);
            if (ax_ff != 2'd2) begin
               ax_in    = ax_nx;
               state_in = ST_MOVE_SET;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ret_ff          <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         time_step_ff    <= gps_pkg::TIME_STEP_RESET;
         source_count_ff <= '0;
         halted_ff       <= 1'b0;
         ax_ff           <= 2'd0;
         src_ff          <= '0;
         cnt_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         ret_ff          <= ret_in;
         rsp_valid_ff    <= rsp_valid_in;
         time_step_ff    <= time_step_in;
         source_count_ff <= source_count_in;
         halted_ff       <= halted_in;
         ax_ff           <= ax_in;
         src_ff          <= src_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      dv_ff   <= dv_in;
      k_ff    <= k_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      one_ff  <= one_in;
      q_ff    <= q_in;
      p_ff    <= p_in;
      v_ff    <= v_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      bend_ff <= bend_in;
      if (rsp_load) begin
         rsp_p_ff    <= p_ff;
         rsp_v_ff    <= v_ff;
         rsp_bend_ff <= bend_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_pos_x     = rsp_p_ff[0];
   assign rsp_new_pos_y     = rsp_p_ff[1];
   assign rsp_new_pos_z     = rsp_p_ff[2];
   assign rsp_new_vel_x     = rsp_v_ff[0];
   assign rsp_new_vel_y     = rsp_v_ff[1];
   assign rsp_new_vel_z     = rsp_v_ff[2];
   assign rsp_batch_end_out = rsp_bend_ff;

   // A halted particle goes straight to the output stage.
   a_halted_bypass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind && halted_ff) |=> (state_ff == ST_FINISH))
      else $error("halted particle did not bypass the arithmetic");

   // A source load finishes in its own cycle and never starts a computation.
   a_load_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind) |=> (state_ff == ST_IDLE))
      else $error("source load started a computation");

   // Table reads stay within the active source count.
   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRC_RD) |-> (src_ff < n_src))
      else $error("source index beyond the active count");

   // A result only appears after the output stage has loaded it.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result appeared outside the output stage");

endmodule
